FILE: rtl/tlpc_pkg.sv
// Types and constants for the pedestrian-button traffic light controller.
// Shared by tlpc_step and traffic_light_pedestrian_controller_core.
package tlpc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_POLLS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_TICKS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_COUNT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_ON_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_OFF_TICKS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WALK_TICKS      = 3'd5;

  localparam logic [2:0] PH_GREEN    = 3'd0;
  localparam logic [2:0] PH_YELLOW   = 3'd1;
  localparam logic [2:0] PH_RED      = 3'd2;
  localparam logic [2:0] PH_PEDBLINK = 3'd3;
  localparam logic [2:0] PH_PEDWALK  = 3'd4;

  localparam logic [1:0] FROM_GREEN   = 2'd0;
  localparam logic [1:0] FROM_NEITHER = 2'd1;
  localparam logic [1:0] FROM_RED     = 2'd2;

  // lamp bit positions: green, yellow, red
  localparam int LAMP_G = 0;
  localparam int LAMP_Y = 1;
  localparam int LAMP_R = 2;

  localparam logic [2:0] LAMPS_G  = 3'b001;
  localparam logic [2:0] LAMPS_R  = 3'b100;
  localparam logic [2:0] LAMPS_RY = 3'b110;

  typedef struct packed {
    logic [7:0]  phase_polls;
    logic [7:0]  poll_ticks;
    logic [3:0]  blink_count;
    logic [7:0]  blink_on_ticks;
    logic [7:0]  blink_off_ticks;
    logic [11:0] walk_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [1:0]  came_from;
    logic        pending;
    logic [11:0] tick;
    logic [7:0]  rounds;
    logic [2:0]  car;
    logic [2:0]  walk;
    logic        joins;
  } state_t;

  localparam cfg_t CFG_RESET = '{
    phase_polls:     8'd50,
    poll_ticks:      8'd2,
    blink_count:     4'd5,
    blink_on_ticks:  8'd5,
    blink_off_ticks: 8'd10,
    walk_ticks:      12'd100
  };

  localparam state_t STATE_RESET = '{
    phase:     PH_GREEN,
    came_from: FROM_NEITHER,
    pending:   1'b0,
    tick:      12'd0,
    rounds:    8'd0,
    car:       LAMPS_G,
    walk:      LAMPS_R,
    joins:     1'b0
  };

endpackage

FILE: rtl/tlpc_step.sv
// Next-state logic for one tick of the traffic light controller.
// Depends on tlpc_pkg for state, configuration types and phase codes.
module tlpc_step (
  input  tlpc_pkg::state_t cur,
  input  tlpc_pkg::cfg_t   cfg,
  input  logic             button,
  output tlpc_pkg::state_t nxt
);

  logic [9:0]  period;
  logic [8:0]  on_off;
  logic [11:0] tick_inc;
  logic [7:0]  round_inc;
  logic        ped;
  logic        lit_now;
  logic        lit_zero;

  function automatic logic blink_lit(input logic [11:0] t, input logic [7:0] on,
                                     input logic [8:0] onoff);
    blink_lit = (t < 12'(on)) || (t >= 12'(onoff));
  endfunction

  assign period    = 10'({cfg.blink_on_ticks, 1'b0}) + 10'(cfg.blink_off_ticks);
  assign on_off    = 9'(cfg.blink_on_ticks) + 9'(cfg.blink_off_ticks);
  assign tick_inc  = cur.tick + 12'd1;
  assign round_inc = cur.rounds + 8'd1;
  assign ped       = (cur.phase == tlpc_pkg::PH_PEDBLINK) ||
                     (cur.phase == tlpc_pkg::PH_PEDWALK);
  assign lit_now   = blink_lit(tick_inc, cfg.blink_on_ticks, on_off);
  assign lit_zero  = blink_lit(12'd0, cfg.blink_on_ticks, on_off);

  always_comb begin
    nxt      = cur;
    nxt.tick = tick_inc;
    if (!ped && button) begin
      nxt.pending = 1'b1;
    end
    case (cur.phase)
      tlpc_pkg::PH_GREEN, tlpc_pkg::PH_RED: begin
        if (tick_inc >= 12'(cfg.poll_ticks)) begin
          nxt.tick   = 12'd0;
          nxt.rounds = round_inc;
          if (nxt.pending) begin
            nxt.phase     = tlpc_pkg::PH_PEDBLINK;
            nxt.rounds    = 8'd0;
            nxt.came_from = (cur.phase == tlpc_pkg::PH_GREEN) ?
                            tlpc_pkg::FROM_GREEN : tlpc_pkg::FROM_RED;
            nxt.joins     = (cur.phase == tlpc_pkg::PH_GREEN);
            nxt.walk      = tlpc_pkg::LAMPS_RY;
            if (cur.phase == tlpc_pkg::PH_GREEN) begin
              nxt.car[tlpc_pkg::LAMP_Y] = 1'b1;
            end
          end else if (round_inc >= cfg.phase_polls) begin
            nxt.phase     = tlpc_pkg::PH_YELLOW;
            nxt.rounds    = 8'd0;
            nxt.came_from = (cur.phase == tlpc_pkg::PH_GREEN) ?
                            tlpc_pkg::FROM_GREEN : tlpc_pkg::FROM_RED;
            nxt.car[tlpc_pkg::LAMP_Y] = 1'b1;
            nxt.walk      = tlpc_pkg::LAMPS_R;
          end
        end
      end
      tlpc_pkg::PH_YELLOW: begin
        if (tick_inc >= 12'(period)) begin
          nxt.tick   = 12'd0;
          nxt.rounds = round_inc;
          if (nxt.pending) begin
            nxt.phase     = tlpc_pkg::PH_PEDBLINK;
            nxt.rounds    = 8'd0;
            nxt.came_from = tlpc_pkg::FROM_NEITHER;
            nxt.joins     = 1'b1;
            nxt.walk      = tlpc_pkg::LAMPS_RY;
            nxt.car[tlpc_pkg::LAMP_Y] = 1'b1;
          end else if (round_inc >= 8'(cfg.blink_count)) begin
            nxt.rounds = 8'd0;
            nxt.walk   = tlpc_pkg::LAMPS_R;
            if (cur.came_from == tlpc_pkg::FROM_GREEN) begin
              nxt.phase = tlpc_pkg::PH_RED;
              nxt.car   = tlpc_pkg::LAMPS_R;
            end else if (cur.came_from == tlpc_pkg::FROM_RED) begin
              nxt.phase = tlpc_pkg::PH_GREEN;
              nxt.car   = tlpc_pkg::LAMPS_G;
            end else begin
              nxt.car[tlpc_pkg::LAMP_Y] = 1'b1;
            end
          end else begin
            nxt.car[tlpc_pkg::LAMP_Y] = lit_zero;
          end
        end else begin
          nxt.car[tlpc_pkg::LAMP_Y] = lit_now;
        end
      end
      tlpc_pkg::PH_PEDBLINK: begin
        if (tick_inc >= 12'(period)) begin
          nxt.tick   = 12'd0;
          nxt.rounds = round_inc;
          if (round_inc >= 8'(cfg.blink_count)) begin
            nxt.phase  = tlpc_pkg::PH_PEDWALK;
            nxt.rounds = 8'd0;
            nxt.car    = tlpc_pkg::LAMPS_R;
            nxt.walk   = tlpc_pkg::LAMPS_G;
          end else begin
            nxt.walk[tlpc_pkg::LAMP_Y] = lit_zero;
            if (cur.joins) begin
              nxt.car[tlpc_pkg::LAMP_Y] = lit_zero;
            end
          end
        end else begin
          nxt.walk[tlpc_pkg::LAMP_Y] = lit_now;
          if (cur.joins) begin
            nxt.car[tlpc_pkg::LAMP_Y] = lit_now;
          end
        end
      end
      tlpc_pkg::PH_PEDWALK: begin
        if (tick_inc >= cfg.walk_ticks) begin
          nxt.pending = 1'b0;
          nxt.tick    = 12'd0;
          nxt.rounds  = 8'd0;
          nxt.walk    = tlpc_pkg::LAMPS_R;
          if (cur.came_from == tlpc_pkg::FROM_GREEN ||
              cur.came_from == tlpc_pkg::FROM_RED) begin
            nxt.phase = tlpc_pkg::PH_YELLOW;
            nxt.car   = tlpc_pkg::LAMPS_RY;
          end else begin
            nxt.phase = tlpc_pkg::PH_GREEN;
            nxt.car   = tlpc_pkg::LAMPS_G;
          end
        end
      end
      default: begin
        nxt.phase  = tlpc_pkg::PH_GREEN;
        nxt.tick   = 12'd0;
        nxt.rounds = 8'd0;
        nxt.car    = tlpc_pkg::LAMPS_G;
        nxt.walk   = tlpc_pkg::LAMPS_R;
      end
    endcase
  end

endmodule

FILE: rtl/traffic_light_pedestrian_controller_core.sv
// Top level of the pedestrian-button traffic light controller.
// Depends on tlpc_pkg and tlpc_step.
//
// Each input word is one tick carrying the button flag; each tick yields one
// result word with the six lamps as they stand after that tick. Unless
// stalled, a word is taken every cycle and its result word is valid the next
// cycle, so the block sustains one tick per clock. The controller state and
// the lamps live in one register bank updated by a single pass of tlpc_step;
// in_stall rises only while a result word is held and stalled at the output.
// Configuration registers are written through the cfg_ port, which is always
// ready, and should be changed only while no tick is in flight.
module traffic_light_pedestrian_controller_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_button,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_car_green,
  output logic                               out_car_yellow,
  output logic                               out_car_red,
  output logic                               out_walk_green,
  output logic                               out_walk_yellow,
  output logic                               out_walk_red,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tlpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tlpc_pkg::state_t st_r;
  tlpc_pkg::state_t st_nxt;
  tlpc_pkg::cfg_t   cfg_r;
  tlpc_pkg::cfg_t   cfg_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             in_acc;

  assign in_stall      = out_valid_r & out_stall;
  assign in_acc        = in_valid & ~in_stall;
  assign out_valid_nxt = in_acc | (out_valid_r & out_stall);
  assign cfg_ready     = 1'b1;

  tlpc_step u_step (
    .cur    (st_r),
    .cfg    (cfg_r),
    .button (in_button),
    .nxt    (st_nxt)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tlpc_pkg::REG_PHASE_POLLS:     cfg_nxt.phase_polls     = cfg_data[7:0];
        tlpc_pkg::REG_POLL_TICKS:      cfg_nxt.poll_ticks      = cfg_data[7:0];
        tlpc_pkg::REG_BLINK_COUNT:     cfg_nxt.blink_count     = cfg_data[3:0];
        tlpc_pkg::REG_BLINK_ON_TICKS:  cfg_nxt.blink_on_ticks  = cfg_data[7:0];
        tlpc_pkg::REG_BLINK_OFF_TICKS: cfg_nxt.blink_off_ticks = cfg_data[7:0];
        tlpc_pkg::REG_WALK_TICKS:      cfg_nxt.walk_ticks      = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= tlpc_pkg::STATE_RESET;
      cfg_r       <= tlpc_pkg::CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        st_r <= st_nxt;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_car_green   = st_r.car[tlpc_pkg::LAMP_G];
  assign out_car_yellow  = st_r.car[tlpc_pkg::LAMP_Y];
  assign out_car_red     = st_r.car[tlpc_pkg::LAMP_R];
  assign out_walk_green  = st_r.walk[tlpc_pkg::LAMP_G];
  assign out_walk_yellow = st_r.walk[tlpc_pkg::LAMP_Y];
  assign out_walk_red    = st_r.walk[tlpc_pkg::LAMP_R];

  a_walk_needs_car_red: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.walk[tlpc_pkg::LAMP_G] |-> st_r.car[tlpc_pkg::LAMP_R])
    else $error("pedestrian green without car red");

  a_no_double_green: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.walk[tlpc_pkg::LAMP_G] && st_r.car[tlpc_pkg::LAMP_G]))
    else $error("car and pedestrian green together");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(st_r))
    else $error("state moved while result word stalled");

  a_ped_has_press: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == tlpc_pkg::PH_PEDBLINK || st_r.phase == tlpc_pkg::PH_PEDWALK)
    |-> st_r.pending)
    else $error("pedestrian sequence without a pending press");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase <= tlpc_pkg::PH_PEDWALK)
    else $error("phase code out of range");

endmodule
